[rtl/core/amom_pkg.sv]
`default_nettype none
package amom_pkg;

  localparam int BLOCK_LEN  = 10;
  localparam int RING_DEPTH = 20;

  localparam int SMP_W  = 16;
  localparam int MAG_W  = 20;
  localparam int ACC_W  = SMP_W + $clog2(BLOCK_LEN);
  localparam int CNT_W  = (BLOCK_LEN > 1) ? $clog2(BLOCK_LEN) : 1;
  localparam int POS_W  = $clog2(RING_DEPTH);
  localparam int TOT_W  = MAG_W + $clog2(RING_DEPTH);
  localparam int MSUM_W = (ACC_W + 2 > MAG_W) ? ACC_W + 2 : MAG_W;

  localparam int DIV_SH  = TOT_W + POS_W;
  localparam int RECIP_W = TOT_W + 1;
  localparam int PROD_W  = TOT_W + RECIP_W;
  localparam logic [RECIP_W-1:0] DIV_RECIP =
    RECIP_W'(((64'd1 << DIV_SH) + 64'(RING_DEPTH) - 64'd1) / 64'(RING_DEPTH));

  localparam logic [MAG_W-1:0] MAG_MAX       = '1;
  localparam logic [MAG_W-1:0] MAX_ACCEL_RST = MAG_W'(983040);

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam int CFG_AW    = 3;
  localparam int CFG_DW    = 32;
  localparam int REG_IDX_W = CFG_AW - 2;
  localparam logic [REG_IDX_W-1:0] REG_MAX_ACCEL = REG_IDX_W'(0);

  typedef logic signed [SMP_W-1:0] smp_t;
  typedef logic signed [ACC_W-1:0] acc_t;
  typedef logic [MAG_W-1:0]        mag_t;

  typedef struct packed {
    acc_t sum_x;
    acc_t sum_y;
    acc_t sum_z;
  } blk_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage
`default_nettype wire

[rtl/core/amom_in_if.sv]
`default_nettype none
interface amom_in_if;
  import amom_pkg::*;

  logic valid;
  logic ready;
  smp_t accel_x;
  smp_t accel_y;
  smp_t accel_z;

  modport source (output valid, output accel_x, output accel_y, output accel_z, input ready);
  modport sink   (input valid, input accel_x, input accel_y, input accel_z, output ready);
endinterface
`default_nettype wire

[rtl/core/amom_out_if.sv]
`default_nettype none
interface amom_out_if;
  import amom_pkg::*;

  logic valid;
  logic ready;
  mag_t block_magnitude;
  logic estop_request;
  logic window_valid;
  mag_t window_average;

  modport source (output valid, output block_magnitude, output estop_request,
                  output window_valid, output window_average, input ready);
  modport sink   (input valid, input block_magnitude, input estop_request,
                  input window_valid, input window_average, output ready);
endinterface
`default_nettype wire

[rtl/core/accel_block_average_overload_monitor_unit.sv]
// Channel | Dir | Handshake        | Beat
// in_ch   | in  | valid/ready      | one three-axis sample (accel_x, accel_y, accel_z)
// out_ch  | out | valid/ready      | one block result (magnitude, estop, window mean)
// cfg     | in  | APB, pready high | max_accel at byte address 0
//
// One sample beat per cycle. A block result leaves, after the last sample beat of its
// block, through a magnitude stage, a ring update stage and a reciprocal-multiply
// output stage. Synchronous reset clears sums, ring, counters and sets max_accel to
// 983040. An output stall holds the back pipeline; a 4-block queue absorbs it, and
// in_ch stalls only at a block end while that queue is full.
`default_nettype none
module accel_block_average_overload_monitor_unit (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  amom_in_if.sink                             in_ch,
  amom_out_if.source                          out_ch,
  input  wire logic                           cfg_psel,
  input  wire logic                           cfg_penable,
  input  wire logic                           cfg_pwrite,
  input  wire logic [amom_pkg::CFG_AW-1:0]    cfg_paddr,
  input  wire logic [amom_pkg::CFG_DW-1:0]    cfg_pwdata,
  output logic      [amom_pkg::CFG_DW-1:0]    cfg_prdata,
  output logic                                cfg_pready
);
  import amom_pkg::*;

  mag_t                 max_accel_r;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 cfg_wr;
  logic                 q_push;
  logic                 q_pop;
  blk_t                 q_wr_blk;
  blk_t                 q_rd_blk;
  q_stat_t              q_stat;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[CFG_AW-1:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (reg_idx == REG_MAX_ACCEL) ? CFG_DW'(max_accel_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_accel_r <= MAX_ACCEL_RST;
    end else if (cfg_wr && reg_idx == REG_MAX_ACCEL) begin
      max_accel_r <= cfg_pwdata[MAG_W-1:0];
    end
  end

  amom_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_stat (q_stat),
    .q_push (q_push),
    .q_blk  (q_wr_blk)
  );

  amom_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wr_blk (q_wr_blk),
    .pop    (q_pop),
    .rd_blk (q_rd_blk),
    .stat   (q_stat)
  );

  amom_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_blk     (q_rd_blk),
    .q_stat    (q_stat),
    .q_pop     (q_pop),
    .max_accel (max_accel_r),
    .out_ch    (out_ch)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.full |-> !(q_push && !q_pop))
    else $error("block queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("block queue underflow");

  a_avg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.window_valid) |-> (out_ch.window_average == '0))
    else $error("window average without window");

  a_push_from_input: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (in_ch.valid && in_ch.ready))
    else $error("block pushed without sample beat");
endmodule
`default_nettype wire

[rtl/core/amom_front.sv]
`default_nettype none
module amom_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  amom_in_if.sink                in_ch,
  input  wire amom_pkg::q_stat_t q_stat,
  output logic                   q_push,
  output amom_pkg::blk_t         q_blk
);
  import amom_pkg::*;

  acc_t             sx_r, sy_r, sz_r;
  acc_t             sx_nxt, sy_nxt, sz_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic             blk_end;
  logic             acc;

  assign blk_end     = (cnt_r == CNT_W'(BLOCK_LEN - 1));
  assign in_ch.ready = !(q_stat.full && blk_end);
  assign acc         = in_ch.valid && in_ch.ready;

  assign sx_nxt = sx_r + ACC_W'(in_ch.accel_x);
  assign sy_nxt = sy_r + ACC_W'(in_ch.accel_y);
  assign sz_nxt = sz_r + ACC_W'(in_ch.accel_z);

  assign q_push      = acc && blk_end;
  assign q_blk.sum_x = sx_nxt;
  assign q_blk.sum_y = sy_nxt;
  assign q_blk.sum_z = sz_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      sx_r  <= '0;
      sy_r  <= '0;
      sz_r  <= '0;
    end else if (acc) begin
      if (blk_end) begin
        cnt_r <= '0;
        sx_r  <= '0;
        sy_r  <= '0;
        sz_r  <= '0;
      end else begin
        cnt_r <= cnt_r + CNT_W'(1);
        sx_r  <= sx_nxt;
        sy_r  <= sy_nxt;
        sz_r  <= sz_nxt;
      end
    end
  end
endmodule
`default_nettype wire

[rtl/core/amom_queue.sv]
`default_nettype none
module amom_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire amom_pkg::blk_t    wr_blk,
  input  wire logic              pop,
  output amom_pkg::blk_t         rd_blk,
  output amom_pkg::q_stat_t      stat
);
  import amom_pkg::*;

  blk_t              q_r [QDEPTH];
  logic [QPTR_W-1:0] wp_r, rp_r;
  logic [QPTR_W:0]   cnt_r;

  assign stat.full  = (cnt_r == (QPTR_W+1)'(QDEPTH));
  assign stat.empty = (cnt_r == '0);
  assign rd_blk     = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= wr_blk;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + QPTR_W'(1);
      end
      if (pop) begin
        rp_r <= rp_r + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + (QPTR_W+1)'(1);
        2'b01:   cnt_r <= cnt_r - (QPTR_W+1)'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end
endmodule
`default_nettype wire

[rtl/core/amom_back.sv]
`default_nettype none
module amom_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire amom_pkg::blk_t    q_blk,
  input  wire amom_pkg::q_stat_t q_stat,
  output logic                   q_pop,
  input  wire amom_pkg::mag_t    max_accel,
  amom_out_if.source             out_ch
);
  import amom_pkg::*;

  logic adv;

  // magnitude
  logic [ACC_W-1:0]  ax, ay, az;
  logic [MSUM_W-1:0] mag_wide;
  mag_t              mag;
  logic              v1_r;
  mag_t              mag1_r;

  // ring
  mag_t              ring_r [RING_DEPTH];
  logic [POS_W-1:0]  pos_r;
  logic [TOT_W-1:0]  total_r;
  logic [TOT_W-1:0]  total_nxt;
  logic              wrap;
  logic              v2_r;
  mag_t              mag2_r;
  logic              est2_r;
  logic              wrap2_r;
  logic [TOT_W-1:0]  tot2_r;

  // mean
  logic [PROD_W-1:0] prod;
  logic              out_vld_r;
  mag_t              out_mag_r;
  logic              out_est_r;
  logic              out_wv_r;
  mag_t              out_avg_r;

  assign adv   = !out_vld_r || out_ch.ready;
  assign q_pop = adv && !q_stat.empty;

  assign ax = q_blk.sum_x[ACC_W-1] ? $unsigned(-q_blk.sum_x) : $unsigned(q_blk.sum_x);
  assign ay = q_blk.sum_y[ACC_W-1] ? $unsigned(-q_blk.sum_y) : $unsigned(q_blk.sum_y);
  assign az = q_blk.sum_z[ACC_W-1] ? $unsigned(-q_blk.sum_z) : $unsigned(q_blk.sum_z);
  assign mag_wide = MSUM_W'(ax) + MSUM_W'(ay) + MSUM_W'(az);
  assign mag      = (mag_wide > MSUM_W'(MAG_MAX)) ? MAG_MAX : mag_wide[MAG_W-1:0];

  assign total_nxt = total_r - TOT_W'(ring_r[pos_r]) + TOT_W'(mag1_r);
  assign wrap      = (pos_r == POS_W'(RING_DEPTH - 1));

  assign prod = PROD_W'(tot2_r) * PROD_W'(DIV_RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      v1_r      <= q_pop;
      v2_r      <= v1_r;
      out_vld_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mag1_r    <= mag;
      mag2_r    <= mag1_r;
      est2_r    <= (mag1_r >= max_accel);
      wrap2_r   <= wrap;
      tot2_r    <= total_nxt;
      out_mag_r <= mag2_r;
      out_est_r <= est2_r;
      out_wv_r  <= wrap2_r;
      out_avg_r <= wrap2_r ? prod[DIV_SH +: MAG_W] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < RING_DEPTH; i++) begin
        ring_r[i] <= '0;
      end
      pos_r   <= '0;
      total_r <= '0;
    end else if (adv && v1_r) begin
      ring_r[pos_r] <= mag1_r;
      pos_r         <= wrap ? '0 : pos_r + POS_W'(1);
      total_r       <= total_nxt;
    end
  end

  assign out_ch.valid           = out_vld_r;
  assign out_ch.block_magnitude = out_mag_r;
  assign out_ch.estop_request   = out_est_r;
  assign out_ch.window_valid    = out_wv_r;
  assign out_ch.window_average  = out_avg_r;
endmodule
`default_nettype wire
